// File: rtl/itad_pkg.sv
// shared types and constants for the integer to ascii digits block
// no dependencies
package itad_pkg;

    // radix select codes on the input tuser
    localparam logic RADIX_DEC = 1'b0;
    localparam logic RADIX_HEX = 1'b1;

    localparam logic [6:0] ASCII_MINUS = 7'h2D;

    // digit value to ascii, index 0 in the low bits
    localparam logic [15:0][6:0] DIGIT_CHARS = {
        7'h46, 7'h45, 7'h44, 7'h43, 7'h42, 7'h41, 7'h39, 7'h38,
        7'h37, 7'h36, 7'h35, 7'h34, 7'h33, 7'h32, 7'h31, 7'h30
    };

    // handoff from the converter to the character emitter
    typedef struct packed {
        logic valid;
        logic neg;
    } t_hand;

endpackage

// File: rtl/integer_to_ascii_digits.sv
// top level of the integer to ascii digits converter
// depends on itad_pkg, itad_conv and itad_emit
//
// usage:
//   input stream: s_axis_tdata carries the value (low VALUE_BITS bits), s_axis_tuser
//   the radix select (0 decimal signed, 1 hex unsigned). a request is taken when
//   s_axis_tvalid and s_axis_tready are both high.
//   output stream: one request per character, most significant first, ascii code
//   in m_axis_tdata[6:0], m_axis_tlast on the final character of the number.
//   decimal negatives get a leading minus, hex uses uppercase letters, zero gives "0".
// timing:
//   decimal: the value is loaded, then shifted in bit by bit with add-3 through a bcd
//   register. hex loads the nibbles directly. the emitter drops one leading zero
//   digit per cycle and sends one character per cycle while the sink is ready.
//   the first character follows the conversion and the leading zero skip. a new value
//   can be taken in the cycle after the emitter picks up the last one, so the converter
//   works on the next value while the emitter still sends the characters of the last.
// reset: synchronous active low, clears both sequencers and the output valid.
// stall: the output register holds its character while m_axis_tready is low;
//   the emitter and then the converter wait behind it, nothing is dropped.
module integer_to_ascii_digits #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,  // value
    input  logic                                   s_axis_tuser,  // radix_select
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [7:0]                             m_axis_tdata,  // ascii_char, zero pad
    output logic                                   m_axis_tlast   // is_last
);
    // decimal digits of a VALUE_BITS magnitude; always at least the hex digit count
    localparam int NDIG = (VALUE_BITS * 31) / 100 + 1;

    itad_pkg::t_hand    hand;
    logic [4*NDIG-1:0]  digits;
    logic               take;
    logic [6:0]         out_char;

    itad_conv #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_value  (s_axis_tdata[VALUE_BITS-1:0]),
        .i_radix  (s_axis_tuser),
        .o_hand   (hand),
        .o_digits (digits),
        .i_take   (take)
    );

    itad_emit #(
        .NDIG (NDIG)
    ) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_hand   (hand),
        .i_digits (digits),
        .o_take   (take),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_char   (out_char),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_char};

    // converter busy right after a request is taken
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again while converting");

    // a minus sign is never the final character
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[6:0] == itad_pkg::ASCII_MINUS) |-> !m_axis_tlast)
        else $error("minus sign marked as last");

    // a handoff is only picked up when the converter offers one
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> hand.valid)
        else $error("emitter took digits that were not ready");

    // reset leaves the output empty and the input open
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("bad state after reset");

endmodule

// File: rtl/itad_conv.sv
// bit-serial binary to bcd converter (shift and add-3), hex loads nibbles directly
// depends on itad_pkg
module itad_conv #(
    parameter int VALUE_BITS = 32,
    parameter int NDIG       = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [VALUE_BITS-1:0]   i_value,
    input  logic                    i_radix,
    output itad_pkg::t_hand         o_hand,
    output logic [4*NDIG-1:0]       o_digits,
    input  logic                    i_take
);
    localparam int DW = 4 * NDIG;
    localparam int CW = $clog2(VALUE_BITS + 1);

    typedef enum logic [1:0] {S_IDLE, S_CONV, S_HOLD} t_state;

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic [DW-1:0]         r_bcd, n_bcd;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_neg, n_neg;
    logic [VALUE_BITS-1:0] mag;
    logic                  neg_in;
    logic [DW-1:0]         adj;

    assign neg_in = (i_radix == itad_pkg::RADIX_DEC) && i_value[VALUE_BITS-1];
    assign mag    = neg_in ? (~i_value + 1'b1) : i_value;

    // add 3 to every bcd digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? (r_bcd[4*i +: 4] + 4'd3)
                                                        : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_neg = neg_in;
                    if (i_radix == itad_pkg::RADIX_HEX) begin
                        n_bcd   = DW'(i_value);
                        n_state = S_HOLD;
                    end else begin
                        n_bin   = mag;
                        n_bcd   = '0;
                        n_cnt   = CW'(VALUE_BITS);
                        n_state = S_CONV;
                    end
                end
            end
            S_CONV: begin
                n_bcd = {adj[DW-2:0], r_bin[VALUE_BITS-1]};
                n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_hand.valid = (r_state == S_HOLD);
    assign o_hand.neg   = r_neg;
    assign o_digits     = r_bcd;

endmodule

// File: rtl/itad_emit.sv
// character emitter: skips leading zeros, sends sign and digits one per request
// depends on itad_pkg
module itad_emit #(
    parameter int NDIG = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  itad_pkg::t_hand     i_hand,
    input  logic [4*NDIG-1:0]   i_digits,
    output logic                o_take,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [6:0]          o_char,
    output logic                o_last
);
    localparam int DW = 4 * NDIG;
    localparam int LW = $clog2(NDIG + 1);

    typedef enum logic [1:0] {E_IDLE, E_SKIP, E_SIGN, E_EMIT} t_state;

    t_state        r_state, n_state;
    logic [DW-1:0] r_dig, n_dig;
    logic [LW-1:0] r_left, n_left;
    logic          r_neg, n_neg;
    logic          r_valid, n_valid;
    logic [6:0]    r_char, n_char;
    logic          r_last, n_last;
    logic          slot;
    logic [3:0]    top;

    assign slot = !r_valid || i_ready;
    assign top  = r_dig[DW-1 -: 4];

    always_comb begin
        n_state = r_state;
        n_dig   = r_dig;
        n_left  = r_left;
        n_neg   = r_neg;
        n_valid = r_valid && !i_ready;
        n_char  = r_char;
        n_last  = r_last;
        case (r_state)
            E_IDLE: begin
                if (i_hand.valid) begin
                    n_dig   = i_digits;
                    n_left  = LW'(NDIG);
                    n_neg   = i_hand.neg;
                    n_state = E_SKIP;
                end
            end
            E_SKIP: begin
                if (top == 4'd0 && r_left > LW'(1)) begin
                    n_dig  = {r_dig[DW-5:0], 4'b0000};
                    n_left = r_left - 1'b1;
                end else begin
                    n_state = r_neg ? E_SIGN : E_EMIT;
                end
            end
            E_SIGN: begin
                if (slot) begin
                    n_valid = 1'b1;
                    n_char  = itad_pkg::ASCII_MINUS;
                    n_last  = 1'b0;
                    n_state = E_EMIT;
                end
            end
            E_EMIT: begin
                if (slot) begin
                    n_valid = 1'b1;
                    n_char  = itad_pkg::DIGIT_CHARS[top];
                    n_last  = (r_left == LW'(1));
                    n_dig   = {r_dig[DW-5:0], 4'b0000};
                    n_left  = r_left - 1'b1;
                    if (r_left == LW'(1)) begin
                        n_state = E_IDLE;
                    end
                end
            end
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_dig  <= n_dig;
        r_left <= n_left;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_take  = (r_state == E_IDLE) && i_hand.valid;
    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule
